[rtl/lrs_pkg.sv]
package lrs_pkg;

	localparam int KEY_WIDTH  = 32;
	localparam int DIGIT_BITS = 8;
	localparam int CAPACITY   = 64;

	localparam int BINS       = 1 << DIGIT_BITS;
	localparam int PASSES     = (KEY_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int HIST_DEPTH = PASSES * BINS;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int PASS_W     = (PASSES > 1) ? $clog2(PASSES) : 1;
	localparam int HS_W       = $clog2(PASSES + 1);
	localparam int FIELD_W    = 32;
	localparam int ITEM_W     = 2 * FIELD_W;

	localparam logic [FIELD_W-1:0] KEY_MASK =
		(KEY_WIDTH >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((64'd1 << KEY_WIDTH) - 64'd1);

	// final sorted set sits in bank 1 when the pass count is odd
	localparam logic OUT_BANK = 1'(PASSES % 2);

	typedef struct packed {
		logic                we;
		logic [IDX_W-1:0]    waddr;
		logic [ITEM_W-1:0]   wdata;
		logic [IDX_W-1:0]    raddr;
	} store_req_t;

	typedef struct packed {
		logic                we;
		logic [HIST_AW-1:0]  waddr;
		logic [CNT_W-1:0]    wdata;
		logic [HIST_AW-1:0]  raddr;
	} hist_req_t;

	// digit of a key for one pass, zero above the key word
	function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [FIELD_W-1:0] k,
			input logic [PASS_W-1:0] p);
		int sh;
		sh = int'(p) * DIGIT_BITS;
		if (sh >= FIELD_W)
			return '0;
		return DIGIT_BITS'(k >> sh);
	endfunction

	function automatic logic [HIST_AW-1:0] hist_addr(input logic [PASS_W-1:0] p,
			input logic [DIGIT_BITS-1:0] d);
		return HIST_AW'((HIST_AW'(p) << DIGIT_BITS) | HIST_AW'(d));
	endfunction

endpackage

[rtl/lrs_ram.sv]
module lrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[rtl/lrs_seq.sv]
module lrs_seq
	import lrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [ITEM_W-1:0] s_tdata,
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [ITEM_W-1:0] m_tdata,
	output logic              m_tlast,
	output logic              m_tuser,
	output store_req_t        b0_req,
	output store_req_t        b1_req,
	output hist_req_t         h_req,
	input  logic [ITEM_W-1:0] b0_rdata,
	input  logic [ITEM_W-1:0] b1_rdata,
	input  logic [CNT_W-1:0]  h_rdata
);

	typedef enum logic [9:0] {
		ST_CLEAR  = 10'b0000000001,
		ST_LOAD   = 10'b0000000010,
		ST_HIST   = 10'b0000000100,
		ST_PREFIX = 10'b0000001000,
		ST_SRD    = 10'b0000010000,
		ST_SHR    = 10'b0000100000,
		ST_SWR    = 10'b0001000000,
		ST_ORD    = 10'b0010000000,
		ST_OLD    = 10'b0100000000,
		ST_OWAIT  = 10'b1000000000
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    idx_q;
	logic                ovf_q;
	logic                last_q;
	logic [FIELD_W-1:0]  key_q;
	logic [HS_W-1:0]     hs_q;
	logic [HIST_AW-1:0]  hcnt_q;
	logic                pf_done_q;
	logic [CNT_W-1:0]    sum_q;
	logic [PASS_W-1:0]   pass_q;
	logic [ITEM_W-1:0]   item_q;
	logic                out_v_q;
	logic [ITEM_W-1:0]   out_data_q;
	logic                out_last_q;
	logic                out_ovf_q;
	logic                hv_s1;
	logic [HIST_AW-1:0]  haddr_s1;

	logic                acc;
	logic                room;
	logic [FIELD_W-1:0]  in_key;
	logic [ITEM_W-1:0]   src_rdata;
	logic [ITEM_W-1:0]   out_rdata;
	logic                idx_end;
	logic [HIST_AW-1:0]  item_haddr;
	logic [PASS_W-1:0]   hs_pass;

	assign s_tready   = (state_q == ST_LOAD);
	assign acc        = s_tvalid && s_tready;
	assign room       = (cnt_q < CNT_W'(CAPACITY));
	assign in_key     = s_tdata[FIELD_W-1:0] & KEY_MASK;
	assign src_rdata  = pass_q[0] ? b1_rdata : b0_rdata;
	assign out_rdata  = OUT_BANK ? b1_rdata : b0_rdata;
	assign idx_end    = (CNT_W'(idx_q + CNT_W'(1)) == cnt_q);
	assign item_haddr = hist_addr(pass_q, digit_of(item_q[FIELD_W-1:0], pass_q));
	assign hs_pass    = PASS_W'(hs_q);

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

	// drive memory ports for each phase
	always_comb begin
		b0_req = '0;
		b1_req = '0;
		h_req  = '0;
		unique case (state_q)
			ST_CLEAR: begin
				h_req.we    = 1'b1;
				h_req.waddr = hcnt_q;
			end
			ST_LOAD: begin
				b0_req.we    = acc && room;
				b0_req.waddr = cnt_q[IDX_W-1:0];
				b0_req.wdata = {s_tdata[ITEM_W-1:FIELD_W], in_key};
			end
			ST_HIST: begin
				h_req.raddr = hist_addr(hs_pass, digit_of(key_q, hs_pass));
				h_req.we    = hv_s1;
				h_req.waddr = haddr_s1;
				h_req.wdata = CNT_W'(h_rdata + CNT_W'(1));
			end
			ST_PREFIX: begin
				h_req.raddr = hcnt_q;
				h_req.we    = hv_s1;
				h_req.waddr = haddr_s1;
				h_req.wdata = (haddr_s1[DIGIT_BITS-1:0] == '0) ? '0 : sum_q;
			end
			ST_SRD: begin
				b0_req.raddr = idx_q[IDX_W-1:0];
				b1_req.raddr = idx_q[IDX_W-1:0];
			end
			ST_SHR: begin
				h_req.raddr = hist_addr(pass_q, digit_of(src_rdata[FIELD_W-1:0], pass_q));
			end
			ST_SWR: begin
				b0_req.we    = pass_q[0];
				b1_req.we    = !pass_q[0];
				b0_req.waddr = h_rdata[IDX_W-1:0];
				b1_req.waddr = h_rdata[IDX_W-1:0];
				b0_req.wdata = item_q;
				b1_req.wdata = item_q;
				h_req.we     = 1'b1;
				h_req.waddr  = item_haddr;
				h_req.wdata  = CNT_W'(h_rdata + CNT_W'(1));
			end
			ST_ORD: begin
				b0_req.raddr = idx_q[IDX_W-1:0];
				b1_req.raddr = idx_q[IDX_W-1:0];
			end
			ST_OLD, ST_OWAIT: begin
			end
			default: begin
			end
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc)
			key_q <= in_key;
		if (state_q == ST_SHR)
			item_q <= src_rdata;
		if (state_q == ST_OLD) begin
			out_data_q <= out_rdata;
			out_last_q <= idx_end;
			out_ovf_q  <= ovf_q;
		end
		haddr_s1 <= h_req.raddr;
	end

	// sequence load, histogram, prefix, scatter, output and clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cnt_q     <= '0;
			idx_q     <= '0;
			ovf_q     <= 1'b0;
			last_q    <= 1'b0;
			hs_q      <= '0;
			hcnt_q    <= '0;
			pf_done_q <= 1'b0;
			sum_q     <= '0;
			pass_q    <= '0;
			out_v_q   <= 1'b0;
			hv_s1     <= 1'b0;
		end else begin
			hv_s1 <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					hcnt_q <= HIST_AW'(hcnt_q + HIST_AW'(1));
					if (hcnt_q == HIST_AW'(HIST_DEPTH - 1)) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					hcnt_q    <= '0;
					pf_done_q <= 1'b0;
					sum_q     <= '0;
					if (acc) begin
						last_q <= s_tlast;
						if (room) begin
							cnt_q   <= CNT_W'(cnt_q + CNT_W'(1));
							hs_q    <= '0;
							state_q <= ST_HIST;
						end else begin
							ovf_q <= 1'b1;
							if (s_tlast)
								state_q <= ST_PREFIX;
						end
					end
				end
				ST_HIST: begin
					if (hs_q != HS_W'(PASSES)) begin
						hv_s1 <= 1'b1;
						hs_q  <= HS_W'(hs_q + HS_W'(1));
					end else if (!hv_s1) begin
						state_q <= last_q ? ST_PREFIX : ST_LOAD;
					end
				end
				ST_PREFIX: begin
					if (!pf_done_q) begin
						hv_s1  <= 1'b1;
						hcnt_q <= HIST_AW'(hcnt_q + HIST_AW'(1));
						if (hcnt_q == HIST_AW'(HIST_DEPTH - 1))
							pf_done_q <= 1'b1;
					end
					// accumulate the running sum, restart at each pass
					if (hv_s1) begin
						if (haddr_s1[DIGIT_BITS-1:0] == '0)
							sum_q <= h_rdata;
						else
							sum_q <= CNT_W'(sum_q + h_rdata);
					end
					if (pf_done_q && !hv_s1) begin
						pass_q  <= '0;
						idx_q   <= '0;
						state_q <= ST_SRD;
					end
				end
				ST_SRD: state_q <= ST_SHR;
				ST_SHR: state_q <= ST_SWR;
				ST_SWR: begin
					if (idx_end) begin
						idx_q <= '0;
						if (pass_q == PASS_W'(PASSES - 1)) begin
							state_q <= ST_ORD;
						end else begin
							pass_q  <= PASS_W'(pass_q + PASS_W'(1));
							state_q <= ST_SRD;
						end
					end else begin
						idx_q   <= CNT_W'(idx_q + CNT_W'(1));
						state_q <= ST_SRD;
					end
				end
				ST_ORD: state_q <= ST_OLD;
				ST_OLD: begin
					out_v_q <= 1'b1;
					state_q <= ST_OWAIT;
				end
				ST_OWAIT: begin
					if (m_tready) begin
						out_v_q <= 1'b0;
						if (out_last_q) begin
							hcnt_q  <= '0;
							state_q <= ST_CLEAR;
						end else begin
							idx_q   <= CNT_W'(idx_q + CNT_W'(1));
							state_q <= ST_ORD;
						end
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

[rtl/lsd_radix_sort_with_tags_core.sv]
// Stable LSD radix sort of up to CAPACITY (64) key/tag requests per set. Keys
// and tags load one request at a time, and no new request is taken until its
// store write and a read-modify-write of one histogram entry per key byte
// through the one read port of the histogram RAM are done, the last write
// retired. A request dropped past capacity is not counted into the histograms.
// The request with tlast set starts the sort: a prefix sweep over the histogram
// RAM, then one scatter pass per key byte with a store read, histogram read and
// write back per item, ping-ponging between two key/tag RAMs. Results then
// leave in ascending key order, equal keys in load order, each read only after
// the one before was accepted downstream; tuser flags a set whose requests
// past capacity were dropped. After reset and after the last result of each
// set, a clearing pass zeroes the histograms; no request is taken during it or
// while a set is sorted.
module lsd_radix_sort_with_tags_core
	import lrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [ITEM_W-1:0] s_tdata,   // key[31:0], tag[63:32]
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [ITEM_W-1:0] m_tdata,   // key_res[31:0], tag_res[63:32]
	output logic              m_tlast,
	output logic [0:0]        m_tuser    // overflow[0]
);

	store_req_t        b0_req;
	store_req_t        b1_req;
	hist_req_t         h_req;
	logic [ITEM_W-1:0] b0_rdata;
	logic [ITEM_W-1:0] b1_rdata;
	logic [CNT_W-1:0]  h_rdata;
	logic              ovf;

	assign m_tuser = ovf;

	// load bank, holds the set after an even number of passes
	lrs_ram #(.WIDTH(ITEM_W), .DEPTH(CAPACITY)) u_bank0 (
		.clk   (clk),
		.we    (b0_req.we),
		.waddr (b0_req.waddr),
		.wdata (b0_req.wdata),
		.raddr (b0_req.raddr),
		.rdata (b0_rdata)
	);

	// spare bank
	lrs_ram #(.WIDTH(ITEM_W), .DEPTH(CAPACITY)) u_bank1 (
		.clk   (clk),
		.we    (b1_req.we),
		.waddr (b1_req.waddr),
		.wdata (b1_req.wdata),
		.raddr (b1_req.raddr),
		.rdata (b1_rdata)
	);

	// per-byte histograms, later bucket offsets
	lrs_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_hist (
		.clk   (clk),
		.we    (h_req.we),
		.waddr (h_req.waddr),
		.wdata (h_req.wdata),
		.raddr (h_req.raddr),
		.rdata (h_rdata)
	);

	lrs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (ovf),
		.b0_req   (b0_req),
		.b1_req   (b1_req),
		.h_req    (h_req),
		.b0_rdata (b0_rdata),
		.b1_rdata (b1_rdata),
		.h_rdata  (h_rdata)
	);

endmodule
